FILE: rtl/bia_pkg.sv
// shared widths, command and status codes for the bitmap id allocator
package bia_pkg;

    // defaults for the top-level parameters; WORD_BITS is a power of two
    localparam int unsigned NUM_IDS_DEF   = 4096;
    localparam int unsigned WORD_BITS_DEF = 32;

    // fixed port widths
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned ID_W     = 12;
    localparam int unsigned WIDX_W   = 7;
    localparam int unsigned WDATA_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CNT_W    = 13;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY  = 3'd0,
        CMD_ALLOC  = 3'd1,
        CMD_FREE   = 3'd2,
        CMD_LOAD   = 3'd3,
        CMD_RESCAN = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_NO_SPACE  = 2'd2,
        ST_FAULT     = 2'd3
    } t_status;

endpackage

FILE: rtl/bia_map_ram.sv
// used-map storage: one write port, one read port, registered read data
module bia_map_ram #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned WIDTH = 32,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bia_word_eval.sv
// per-word evaluation: in-range used count and first clear bit at or above a start bit
module bia_word_eval #(
    parameter int unsigned WORD_BITS = 32,
    parameter int unsigned SW = 13,
    localparam int unsigned BW = $clog2(WORD_BITS),
    localparam int unsigned LW = BW + 1
) (
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [SW-1:0]        i_base,
    input  logic [SW-1:0]        i_limit,
    input  logic [LW-1:0]        i_lo,
    output logic                 o_found,
    output logic [BW-1:0]        o_pos,
    output logic [LW-1:0]        o_used
);

    logic [SW-1:0]        room;
    logic [WORD_BITS-1:0] in_map;
    logic [WORD_BITS-1:0] avail;

    always_comb begin
        // ids from this word's base up to the id limit; bits below this count are in range
        room = (i_limit > i_base) ? (i_limit - i_base) : '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            in_map[j] = SW'(j) < room;
            avail[j]  = in_map[j] && !i_word[j] && (LW'(j) >= i_lo);
        end
        o_used  = LW'($countones(in_map & i_word));
        o_found = |avail;
        o_pos   = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (avail[j]) begin
                o_pos = BW'(j);
            end
        end
    end

endmodule

FILE: rtl/bia_ctrl.sv
// command sequencer: read-modify-write of map words, forward search and rescan sweep
module bia_ctrl #(
    parameter int unsigned NUM_IDS = bia_pkg::NUM_IDS_DEF,
    parameter int unsigned WORD_BITS = bia_pkg::WORD_BITS_DEF,
    localparam int unsigned MAP_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS,
    localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
    localparam int unsigned BW = $clog2(WORD_BITS),
    localparam int unsigned SW = AW + BW + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bia_pkg::CMD_W-1:0]     i_cmd,
    input  logic [bia_pkg::ID_W-1:0]      i_node_id,
    input  logic [bia_pkg::WIDX_W-1:0]    i_word_index,
    input  logic [bia_pkg::WDATA_W-1:0]   i_word_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bia_pkg::STATUS_W-1:0]  o_status,
    output logic [bia_pkg::CNT_W-1:0]     o_granted_id,
    output logic [bia_pkg::CNT_W-1:0]     o_free_left,
    input  logic                          i_cfg_we,
    input  logic [bia_pkg::CNT_W-1:0]     i_cfg_data,
    output logic                          o_map_re,
    output logic [AW-1:0]                 o_map_raddr,
    input  logic [WORD_BITS-1:0]          i_map_rdata,
    output logic                          o_map_we,
    output logic [AW-1:0]                 o_map_waddr,
    output logic [WORD_BITS-1:0]          o_map_wdata,
    output logic [WORD_BITS-1:0]          o_eval_word,
    output logic [SW-1:0]                 o_eval_base,
    output logic [SW-1:0]                 o_eval_limit,
    output logic [BW:0]                   o_eval_lo,
    input  logic                          i_eval_found,
    input  logic [BW-1:0]                 i_eval_pos,
    input  logic [BW:0]                   i_eval_used
);

    import bia_pkg::*;

    localparam int unsigned IW = $clog2(NUM_IDS + 1);
    localparam int unsigned CW = (ID_W > SW) ? ID_W : SW;
    localparam int unsigned LW = BW + 1;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_EXEC   = 6'b000100,
        S_SCAN   = 6'b001000,
        S_RESCAN = 6'b010000,
        S_POST   = 6'b100000
    } t_state;

    // control state
    t_state             r_state,      n_state;
    logic [AW-1:0]      r_clr_addr,   n_clr_addr;
    logic [IW-1:0]      r_id_count,   n_id_count;
    logic [IW-1:0]      r_free_count, n_free_count;
    logic [IW-1:0]      r_next_free,  n_next_free;
    logic               r_out_valid,  n_out_valid;

    // request and working registers
    logic [CMD_W-1:0]   r_cmd,        n_cmd;
    logic [ID_W-1:0]    r_id,         n_id;
    logic [WIDX_W-1:0]  r_widx,       n_widx;
    logic [WDATA_W-1:0] r_wdata,      n_wdata;
    logic [AW-1:0]      r_scan_word,  n_scan_word;
    logic [IW-1:0]      r_used,       n_used;
    logic               r_hint_found, n_hint_found;
    logic [IW-1:0]      r_hint,       n_hint;
    t_status            r_res_status, n_res_status;
    logic [IW-1:0]      r_res_granted, n_res_granted;
    t_status            r_out_status, n_out_status;
    logic [CNT_W-1:0]   r_out_granted, n_out_granted;
    logic [CNT_W-1:0]   r_out_free,   n_out_free;

    logic [AW-1:0]      alloc_word;
    logic [BW-1:0]      alloc_bit;
    logic [AW-1:0]      id_word;
    logic [BW-1:0]      id_bit;
    logic               id_out;
    logic               hint_out;
    logic               word_end;
    logic [IW-1:0]      eval_hit_id;
    logic [IW-1:0]      used_sum;

    assign alloc_word = AW'(r_next_free >> BW);
    assign alloc_bit  = r_next_free[BW-1:0];
    assign id_word    = AW'(r_id >> BW);
    assign id_bit     = r_id[BW-1:0];
    assign id_out     = CW'(r_id) >= CW'(r_id_count);
    assign hint_out   = r_next_free >= r_id_count;

    // the alloc step searches the word it just marked; the sweeps see plain read data
    always_comb begin
        if (r_state == S_EXEC) begin
            o_eval_word = i_map_rdata | (WORD_BITS'(1) << alloc_bit);
            o_eval_base = SW'(alloc_word) << BW;
            o_eval_lo   = LW'(alloc_bit) + LW'(1);
        end else begin
            o_eval_word = i_map_rdata;
            o_eval_base = SW'(r_scan_word) << BW;
            o_eval_lo   = '0;
        end
    end

    assign o_eval_limit = SW'(r_id_count);
    assign word_end     = (o_eval_base + SW'(WORD_BITS)) >= SW'(r_id_count);
    assign eval_hit_id  = IW'(o_eval_base + SW'(i_eval_pos));
    assign used_sum     = r_used + IW'(i_eval_used);

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_id_count    = r_id_count;
        n_free_count  = r_free_count;
        n_next_free   = r_next_free;
        n_out_valid   = r_out_valid;
        n_cmd         = r_cmd;
        n_id          = r_id;
        n_widx        = r_widx;
        n_wdata       = r_wdata;
        n_scan_word   = r_scan_word;
        n_used        = r_used;
        n_hint_found  = r_hint_found;
        n_hint        = r_hint;
        n_res_status  = r_res_status;
        n_res_granted = r_res_granted;
        n_out_status  = r_out_status;
        n_out_granted = r_out_granted;
        n_out_free    = r_out_free;
        o_map_re      = 1'b0;
        o_map_raddr   = '0;
        o_map_we      = 1'b0;
        o_map_waddr   = r_clr_addr;
        o_map_wdata   = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                o_map_we   = 1'b1;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_cmd;
                    n_id     = i_node_id;
                    n_widx   = i_word_index;
                    n_wdata  = i_word_data;
                    n_state  = S_EXEC;
                    o_map_re = 1'b1;
                    case (i_cmd)
                        CMD_ALLOC: begin
                            o_map_raddr = alloc_word;
                        end
                        CMD_RESCAN: begin
                            o_map_raddr  = '0;
                            n_scan_word  = '0;
                            n_used       = '0;
                            n_hint_found = 1'b0;
                            n_state      = S_RESCAN;
                        end
                        default: begin
                            o_map_raddr = AW'(i_node_id >> BW);
                        end
                    endcase
                end
            end
            S_EXEC: begin
                n_state       = S_POST;
                n_res_status  = ST_OK;
                n_res_granted = '0;
                case (r_cmd)
                    CMD_QUERY: begin
                        if (r_id != '0 && (id_out || !i_map_rdata[id_bit])) begin
                            n_res_status = ST_NOT_FOUND;
                        end
                    end
                    CMD_ALLOC: begin
                        if (r_free_count == '0) begin
                            n_res_status = ST_NO_SPACE;
                        end else if (hint_out || i_map_rdata[alloc_bit]) begin
                            n_res_status = ST_FAULT;
                        end else begin
                            o_map_we      = 1'b1;
                            o_map_waddr   = alloc_word;
                            o_map_wdata   = o_eval_word;
                            n_free_count  = r_free_count - IW'(1);
                            n_res_granted = r_next_free;
                            if (i_eval_found) begin
                                n_next_free = eval_hit_id;
                            end else if (word_end) begin
                                n_next_free = r_id_count;
                            end else begin
                                n_scan_word = alloc_word + AW'(1);
                                o_map_re    = 1'b1;
                                o_map_raddr = alloc_word + AW'(1);
                                n_state     = S_SCAN;
                            end
                        end
                    end
                    CMD_FREE: begin
                        if (id_out || !i_map_rdata[id_bit]) begin
                            n_res_status = ST_FAULT;
                        end else begin
                            o_map_we    = 1'b1;
                            o_map_waddr = id_word;
                            o_map_wdata = i_map_rdata & ~(WORD_BITS'(1) << id_bit);
                            if (CW'(r_next_free) > CW'(r_id)) begin
                                n_next_free = IW'(r_id);
                            end
                            if (r_free_count < IW'(NUM_IDS)) begin
                                n_free_count = r_free_count + IW'(1);
                            end
                        end
                    end
                    CMD_LOAD: begin
                        // a word index past the map is dropped
                        if (32'(r_widx) < MAP_WORDS) begin
                            o_map_we    = 1'b1;
                            o_map_waddr = AW'(r_widx);
                            o_map_wdata = WORD_BITS'(r_wdata);
                        end
                    end
                    default: begin
                        n_res_status = ST_FAULT;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_eval_found) begin
                    n_next_free = eval_hit_id;
                    n_state     = S_POST;
                end else if (word_end) begin
                    n_next_free = r_id_count;
                    n_state     = S_POST;
                end else begin
                    n_scan_word = r_scan_word + AW'(1);
                    o_map_re    = 1'b1;
                    o_map_raddr = r_scan_word + AW'(1);
                end
            end
            S_RESCAN: begin
                n_used = used_sum;
                if (!r_hint_found && i_eval_found) begin
                    n_hint_found = 1'b1;
                    n_hint       = eval_hit_id;
                end
                if (word_end) begin
                    n_free_count  = r_id_count - used_sum;
                    n_res_status  = ST_OK;
                    n_res_granted = '0;
                    n_state       = S_POST;
                    if (r_hint_found) begin
                        n_next_free = r_hint;
                    end else if (i_eval_found) begin
                        n_next_free = eval_hit_id;
                    end else begin
                        n_next_free = r_id_count;
                    end
                end else begin
                    n_scan_word = r_scan_word + AW'(1);
                    o_map_re    = 1'b1;
                    o_map_raddr = r_scan_word + AW'(1);
                end
            end
            S_POST: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_granted = CNT_W'(r_res_granted);
                    n_out_free    = CNT_W'(r_free_count);
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // id_count write: zero becomes one, clamp to the map size
        if (i_cfg_we) begin
            if (i_cfg_data == '0) begin
                n_id_count = IW'(1);
            end else if (32'(i_cfg_data) > NUM_IDS) begin
                n_id_count = IW'(NUM_IDS);
            end else begin
                n_id_count = IW'(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_id_count   <= IW'(NUM_IDS);
            r_free_count <= IW'(NUM_IDS);
            r_next_free  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_id_count   <= n_id_count;
            r_free_count <= n_free_count;
            r_next_free  <= n_next_free;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_id          <= n_id;
        r_widx        <= n_widx;
        r_wdata       <= n_wdata;
        r_scan_word   <= n_scan_word;
        r_used        <= n_used;
        r_hint_found  <= n_hint_found;
        r_hint        <= n_hint;
        r_res_status  <= n_res_status;
        r_res_granted <= n_res_granted;
        r_out_status  <= n_out_status;
        r_out_granted <= n_out_granted;
        r_out_free    <= n_out_free;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_granted_id = r_out_granted;
    assign o_free_left  = r_out_free;

endmodule

FILE: rtl/bitmap_id_allocator.sv
// top level of the bitmap id allocator: map memory, word evaluator and sequencer
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------------
//  request   | i_in_valid / o_in_ready    | i_cmd, i_node_id, i_word_index, i_word_data
//  result    | o_out_valid / i_out_ready  | o_status, o_granted_id, o_free_left
//  id_count  | i_cfg_we                   | i_cfg_data
//
// query, free, load and unknown codes run an execute step, then a post step.
// alloc may add scan steps that read further map words while searching for the hint.
// rescan reads each map word below id_count in turn, one map read per word.
// after reset a clearing pass writes zeros to all MAP_WORDS map words
// while o_in_ready stays low.
// a finished result waits in the output register; a request already in work
// holds in its last step until that register frees.
module bitmap_id_allocator #(
    parameter int unsigned NUM_IDS = bia_pkg::NUM_IDS_DEF,
    parameter int unsigned WORD_BITS = bia_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bia_pkg::CMD_W-1:0]     i_cmd,
    input  logic [bia_pkg::ID_W-1:0]      i_node_id,
    input  logic [bia_pkg::WIDX_W-1:0]    i_word_index,
    input  logic [bia_pkg::WDATA_W-1:0]   i_word_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bia_pkg::STATUS_W-1:0]  o_status,
    output logic [bia_pkg::CNT_W-1:0]     o_granted_id,
    output logic [bia_pkg::CNT_W-1:0]     o_free_left,
    input  logic                          i_cfg_we,
    input  logic [bia_pkg::CNT_W-1:0]     i_cfg_data
);

    import bia_pkg::*;

    localparam int unsigned MAP_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned BW = $clog2(WORD_BITS);
    localparam int unsigned SW = AW + BW + 1;

    logic                 map_re;
    logic [AW-1:0]        map_raddr;
    logic [WORD_BITS-1:0] map_rdata;
    logic                 map_we;
    logic [AW-1:0]        map_waddr;
    logic [WORD_BITS-1:0] map_wdata;
    logic [WORD_BITS-1:0] eval_word;
    logic [SW-1:0]        eval_base;
    logic [SW-1:0]        eval_limit;
    logic [BW:0]          eval_lo;
    logic                 eval_found;
    logic [BW-1:0]        eval_pos;
    logic [BW:0]          eval_used;

    bia_map_ram #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WORD_BITS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    bia_word_eval #(
        .WORD_BITS (WORD_BITS),
        .SW        (SW)
    ) u_eval (
        .i_word  (eval_word),
        .i_base  (eval_base),
        .i_limit (eval_limit),
        .i_lo    (eval_lo),
        .o_found (eval_found),
        .o_pos   (eval_pos),
        .o_used  (eval_used)
    );

    bia_ctrl #(
        .NUM_IDS   (NUM_IDS),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_node_id    (i_node_id),
        .i_word_index (i_word_index),
        .i_word_data  (i_word_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_granted_id (o_granted_id),
        .o_free_left  (o_free_left),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_map_re     (map_re),
        .o_map_raddr  (map_raddr),
        .i_map_rdata  (map_rdata),
        .o_map_we     (map_we),
        .o_map_waddr  (map_waddr),
        .o_map_wdata  (map_wdata),
        .o_eval_word  (eval_word),
        .o_eval_base  (eval_base),
        .o_eval_limit (eval_limit),
        .o_eval_lo    (eval_lo),
        .i_eval_found (eval_found),
        .i_eval_pos   (eval_pos),
        .i_eval_used  (eval_used)
    );

    // one request at a time: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in work");

    // the map is never written while the block waits for a request
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_we |-> !o_in_ready)
        else $error("map write while idle");

    // only a successful alloc hands out a nonzero id
    a_grant_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_granted_id == '0))
        else $error("granted id on a failed request");

    // the free count never exceeds the map size
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_free_left) <= NUM_IDS))
        else $error("free count above map size");

endmodule

FILE: tb/bia_checker.sv
// request/result checker for the bitmap id allocator: predicts each result and compares
`timescale 1ns / 100ps

module bia_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [bia_pkg::CMD_W-1:0]     i_cmd,
    input  logic [bia_pkg::ID_W-1:0]      i_node_id,
    input  logic [bia_pkg::WIDX_W-1:0]    i_word_index,
    input  logic [bia_pkg::WDATA_W-1:0]   i_word_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [bia_pkg::STATUS_W-1:0]  i_status,
    input  logic [bia_pkg::CNT_W-1:0]     i_granted_id,
    input  logic [bia_pkg::CNT_W-1:0]     i_free_left,
    input  logic                          i_cfg_we,
    input  logic [bia_pkg::CNT_W-1:0]     i_cfg_data,
    output int                            o_mismatches,
    output int                            o_pending
);
    import bia_pkg::*;

    localparam int unsigned WB        = WORD_BITS_DEF;
    localparam int unsigned MAP_WORDS = NUM_IDS_DEF / WORD_BITS_DEF;

    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] granted;
        logic [CNT_W-1:0] free_left;
    } t_outcome;

    logic [WB-1:0]    map_words [MAP_WORDS];
    logic [CNT_W-1:0] id_limit;
    logic [CNT_W-1:0] free_ids;
    logic [CNT_W-1:0] scan_hint;
    t_outcome         awaited_outcomes [$];
    int               mismatch_total = 0;
    int               backlog = 0;

    assign o_mismatches = mismatch_total;
    assign o_pending    = backlog;

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
        mismatch_total++;
    endtask

    // callers keep id below NUM_IDS
    function automatic logic id_in_use(input int unsigned id);
        return map_words[id / WB][id % WB];
    endfunction

    function automatic logic [CNT_W-1:0] first_clear_from(input int unsigned start);
        for (int unsigned i = start; i < id_limit; i++) begin
            if (!id_in_use(i))
                return CNT_W'(i);
        end
        return id_limit;
    endfunction

    task automatic set_id_limit(input logic [CNT_W-1:0] value);
        if (value == 0)
            id_limit = 1;
        else if (value > NUM_IDS_DEF)
            id_limit = NUM_IDS_DEF;
        else
            id_limit = value;
    endtask

    task automatic predict_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                   input logic [WIDX_W-1:0] widx,
                                   input logic [WDATA_W-1:0] wdata);
        t_outcome    r;
        int unsigned used;
        r.status  = ST_OK;
        r.granted = '0;
        case (cmd)
            CMD_QUERY: begin
                if (id != 0 && (id >= id_limit || !id_in_use(id)))
                    r.status = ST_NOT_FOUND;
            end
            CMD_ALLOC: begin
                if (free_ids == 0) begin
                    r.status = ST_NO_SPACE;
                end else if (scan_hint >= id_limit || id_in_use(scan_hint)) begin
                    r.status = ST_FAULT;
                end else begin
                    r.granted = scan_hint;
                    map_words[scan_hint / WB][scan_hint % WB] = 1'b1;
                    free_ids  = free_ids - 1'b1;
                    scan_hint = first_clear_from(scan_hint + 1);
                end
            end
            CMD_FREE: begin
                if (id >= id_limit || !id_in_use(id)) begin
                    r.status = ST_FAULT;
                end else begin
                    map_words[id / WB][id % WB] = 1'b0;
                    if (scan_hint > id)
                        scan_hint = CNT_W'(id);
                    // count saturates at the map size
                    if (free_ids < NUM_IDS_DEF)
                        free_ids = free_ids + 1'b1;
                end
            end
            CMD_LOAD: begin
                if (widx < MAP_WORDS)
                    map_words[widx] = wdata[WB-1:0];
            end
            CMD_RESCAN: begin
                used = 0;
                for (int unsigned i = 0; i < id_limit; i++) begin
                    if (id_in_use(i))
                        used++;
                end
                free_ids  = id_limit - CNT_W'(used);
                scan_hint = first_clear_from(0);
            end
            default: r.status = ST_FAULT;
        endcase
        r.free_left = free_ids;
        awaited_outcomes.push_back(r);
    endtask

    task automatic check_result();
        t_outcome want;
        if (awaited_outcomes.size() == 0) begin
            flag_mismatch("outstanding request count", 1, 0);
        end else begin
            want = awaited_outcomes.pop_front();
            if (i_status != want.status)
                flag_mismatch("status", want.status, i_status);
            if (i_granted_id != want.granted)
                flag_mismatch("granted_id", want.granted, i_granted_id);
            if (i_free_left != want.free_left)
                flag_mismatch("free_left", want.free_left, i_free_left);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (map_words[w])
                map_words[w] = '0;
            id_limit  = NUM_IDS_DEF;
            free_ids  = NUM_IDS_DEF;
            scan_hint = '0;
            awaited_outcomes.delete();
        end else begin
            if (i_cfg_we)
                set_id_limit(i_cfg_data);
            if (i_in_valid && i_in_ready)
                predict_request(i_cmd, i_node_id, i_word_index, i_word_data);
            if (i_out_valid && i_out_ready)
                check_result();
        end
        backlog <= awaited_outcomes.size();
    end

endmodule

FILE: tb/testbench.sv
// top of the bitmap id allocator testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps

module testbench;
    import bia_pkg::*;

    logic                i_clk;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_ready;
    logic [CMD_W-1:0]    i_cmd        = '0;
    logic [ID_W-1:0]     i_node_id    = '0;
    logic [WIDX_W-1:0]   i_word_index = '0;
    logic [WDATA_W-1:0]  i_word_data  = '0;
    logic                o_out_valid;
    logic                i_out_ready  = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [CNT_W-1:0]    o_granted_id;
    logic [CNT_W-1:0]    o_free_left;
    logic                i_cfg_we     = 1'b0;
    logic [CNT_W-1:0]    i_cfg_data   = '0;

    int                  mismatches;
    int                  backlog;

    int unsigned         send_idle_pct  = 25;
    int unsigned         recv_stall_pct = 63;
    int unsigned         requests_sent  = 0;
    int unsigned         allocs_sent    = 0;
    int unsigned         id_span        = NUM_IDS_DEF;

    // receiver hold-off state
    int unsigned         results_taken = 0;
    int unsigned         hold_left     = 0;
    logic                hold_done     = 1'b0;

    bitmap_id_allocator u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_node_id    (i_node_id),
        .i_word_index (i_word_index),
        .i_word_data  (i_word_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_granted_id (o_granted_id),
        .o_free_left  (o_free_left),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    bia_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_node_id    (i_node_id),
        .i_word_index (i_word_index),
        .i_word_data  (i_word_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_status     (o_status),
        .i_granted_id (o_granted_id),
        .i_free_left  (o_free_left),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (backlog)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // result side: random stalls, plus one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && results_taken >= 300) begin
            i_out_ready <= 1'b0;
            hold_done   <= 1'b1;
            hold_left   <= 400;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
        if (o_out_valid && i_out_ready)
            results_taken <= results_taken + 1;
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd, input int unsigned id,
                                input int unsigned widx, input logic [WDATA_W-1:0] wdata);
        if (requests_sent < 700) begin
            send_idle_pct  = 25;
            recv_stall_pct = 63;
        end else if (requests_sent < 1400) begin
            send_idle_pct  = 63;
            recv_stall_pct = 25;
        end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_node_id    <= id[ID_W-1:0];
        i_word_index <= widx[WIDX_W-1:0];
        i_word_data  <= wdata;
        do @(posedge i_clk); while (!o_in_ready);
        requests_sent++;
        if (cmd == CMD_ALLOC)
            allocs_sent++;
    endtask

    task automatic write_id_count(input int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value[CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (value == 0)
            id_span = 1;
        else if (value > NUM_IDS_DEF)
            id_span = NUM_IDS_DEF;
        else
            id_span = value;
        allocs_sent = 0;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (backlog != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // ids mostly near the allocated region so frees and queries hit set bits
    task automatic random_request();
        int unsigned        pick;
        int unsigned        region;
        int unsigned        id;
        int unsigned        widx;
        logic [WDATA_W-1:0] wdata;
        logic [CMD_W-1:0]   cmd;
        pick   = $urandom_range(0, 99);
        region = allocs_sent + 8;
        if (region > id_span - 1)
            region = id_span - 1;
        id   = ($urandom_range(0, 9) < 7) ? $urandom_range(0, region) : $urandom_range(0, 4095);
        widx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, region / 32)
                                          : $urandom_range(0, 127);
        case ($urandom_range(0, 3))
            0: wdata = '0;
            1: wdata = '1;
            2: wdata = 32'h1 << $urandom_range(0, 31);
            default: wdata = $urandom();
        endcase
        if (pick < 30)
            cmd = CMD_ALLOC;
        else if (pick < 50)
            cmd = CMD_FREE;
        else if (pick < 68)
            cmd = CMD_QUERY;
        else if (pick < 80)
            cmd = CMD_LOAD;
        else if (pick < 92)
            cmd = CMD_RESCAN;
        else
            cmd = CMD_W'($urandom_range(5, 7));
        send_request(cmd, id, widx, wdata);
    endtask

    initial begin
        static int unsigned id_counts [8] = '{0, 33, 1, 8191, 40, 4095, 100, 4096};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // map clearing pass after reset
        do @(posedge i_clk); while (!o_in_ready);
        write_id_count(4096);

        send_request(CMD_LOAD,   0,    3,   32'h0000_0001);
        send_request(CMD_FREE,   96,   0,   '0);            // count already at the top
        send_request(CMD_QUERY,  0,    0,   '0);
        send_request(CMD_QUERY,  4095, 0,   '0);
        send_request(CMD_ALLOC,  0,    0,   '0);
        send_request(CMD_QUERY,  0,    0,   '0);
        send_request(CMD_QUERY,  1,    0,   '0);
        send_request(CMD_ALLOC,  0,    0,   '0);
        send_request(CMD_FREE,   0,    0,   '0);
        send_request(CMD_FREE,   0,    0,   '0);
        send_request(CMD_FREE,   4095, 0,   '0);
        send_request(CMD_LOAD,   0,    0,   32'hFFFF_FFFF);
        send_request(CMD_ALLOC,  0,    0,   '0);            // hinted bit already set
        send_request(CMD_RESCAN, 0,    0,   '0);
        send_request(CMD_ALLOC,  0,    0,   '0);
        send_request(CMD_LOAD,   0,    127, 32'h8000_0001);
        send_request(CMD_QUERY,  4095, 0,   '0);
        send_request(CMD_QUERY,  4064, 0,   '0);
        send_request(CMD_FREE,   4095, 0,   '0);
        send_request(CMD_LOAD,   0,    1,   32'h5555_AAAA);
        send_request(CMD_W'(5),  17,   9,   32'h1234_5678);
        send_request(CMD_W'(6),  2048, 64,  32'h8000_0000);
        send_request(CMD_W'(7),  4095, 127, 32'hFFFF_FFFF);
        send_request(CMD_RESCAN, 0,    0,   '0);
        wait_drained();

        foreach (id_counts[p]) begin
            write_id_count(id_counts[p]);
            if ($urandom_range(0, 1))
                send_request(CMD_RESCAN, 0, 0, '0);
            repeat (250)
                random_request();
            wait_drained();
        end

        if (mismatches == 0 && backlog == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
